>>> hdl/i2cm_pkg.sv
package i2cm_pkg;

   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [7:0] TICKS_PER_DELAY_RESET = 8'd50;
   localparam int         QUEUE_DEPTH           = 2;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] tx_byte;
      logic       nack_after_read;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_driving;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
   } rsp_type;

endpackage

>>> hdl/i2c_master_bit_engine.sv
// I2C master byte engine driven by one timer tick per transaction.
// Request channel: each tick is pushed as a transaction holding the command,
// the byte to send, the ACK or NACK choice and the sampled SDA level; a
// transaction is taken at a clock edge with push high and full low.
// Response channel: one transaction per request, in order, carrying the pin
// levels, busy, done, the last received byte and the acknowledge flag; it is
// on rsp_item while empty is low and leaves at an edge with pop high.
// The CSR port writes the ticks-per-delay register; the user must write it
// only while no request is outstanding; the block does not enforce this.
// Throughput is one transaction per cycle while the response queue is not
// full. A request taken at an edge waits in the request queue while the
// engine computes its step, and the response is then written into the
// response queue and shows on rsp_item.
// Reset empties both queues, idles the engine with SCL and SDA driven high
// and loads 50 ticks per delay. When the response side stalls, the engine
// holds and the request queue fills until full is raised.
module i2c_master_bit_engine
   import i2cm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  req_type    req_item,
   output logic       full,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_item,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   req_type item;
   logic    item_valid;
   logic    item_take;
   logic    rsp_full;
   logic    rsp_push;
   rsp_type rsp_next;
   logic [$bits(rsp_type)-1:0] rsp_rdata;

   i2cm_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_item   (req_item),
      .full       (full),
      .item_take  (item_take),
      .item       (item),
      .item_valid (item_valid)
   );

   i2cm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .rsp_full         (rsp_full),
      .rsp_push         (rsp_push),
      .rsp_next         (rsp_next)
   );

   i2cm_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_next),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rdata),
      .empty (empty)
   );

   assign rsp_item = rsp_type'(rsp_rdata);

endmodule

>>> hdl/i2cm_fifo.sv
module i2cm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> hdl/i2cm_front.sv
module i2cm_front
   import i2cm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_item,
   output logic    full,
   input  logic    item_take,
   output req_type item,
   output logic    item_valid
);

   req_type classified;
   logic    queue_empty;
   logic [$bits(req_type)-1:0] queue_rdata;

   // Unused command codes are turned into no command here.
   always_comb begin
      classified = req_item;
      if (req_item.command > CMD_READ) begin
         classified.command = CMD_NONE;
      end
   end

   i2cm_fifo #(
      .WIDTH ($bits(req_type)),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (classified),
      .full  (full),
      .pop   (item_take),
      .rdata (queue_rdata),
      .empty (queue_empty)
   );

   assign item       = req_type'(queue_rdata);
   assign item_valid = !queue_empty;

endmodule

>>> hdl/i2cm_back.sv
module i2cm_back
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       item_valid,
   input  req_type    item,
   output logic       item_take,
   input  logic       rsp_full,
   output logic       rsp_push,
   output rsp_type    rsp_next
);

   logic [7:0] ticks_ff;
   logic [2:0] active_ff, active_in;
   logic [5:0] phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] divider_ff, divider_in;
   logic       nack_ff, nack_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       drive_ff, drive_in;
   logic       ack_ff, ack_in;
   logic [7:0] rx_hold_ff, rx_hold_in;

   logic [7:0] limit;
   logic [7:0] divider_inc;
   logic       run;
   logic       last;
   logic       step;

   assign step      = item_valid && !rsp_full;
   assign item_take = step;
   assign rsp_push  = step;
   assign limit     = (ticks_ff == 8'd0) ? 8'd1 : ticks_ff;

   always_comb begin
      active_in    = active_ff;
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      divider_in   = divider_ff;
      nack_in      = nack_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      drive_in     = drive_ff;
      ack_in       = ack_ff;
      rx_hold_in   = rx_hold_ff;
      divider_inc  = divider_ff + 8'd1;
      run          = 1'b0;
      last         = 1'b0;

      if (active_ff == CMD_NONE) begin
         if (item.command != CMD_NONE) begin
            active_in    = item.command;
            phase_in     = '0;
            divider_in   = '0;
            bit_count_in = '0;
            if (item.command == CMD_WRITE) begin
               shift_in = item.tx_byte;
            end else if (item.command == CMD_READ) begin
               shift_in = '0;
               nack_in  = item.nack_after_read;
            end
            run = 1'b1;
         end
      end else if (divider_inc >= limit) begin
         divider_in = '0;
         phase_in   = phase_ff + 6'd1;
         run        = 1'b1;
      end else begin
         divider_in = divider_inc;
      end

      if (run) begin
         unique case (active_in)
            CMD_START: begin
               if (phase_in == 6'd1) begin
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end else if (phase_in == 6'd2 || phase_in == 6'd3) begin
                  sda_in = 1'b0;
               end else if (phase_in >= 6'd4) begin
                  scl_in = 1'b0;
                  last   = 1'b1;
               end
            end
            CMD_STOP: begin
               if (phase_in == 6'd0) begin
                  scl_in = 1'b0;
                  sda_in = 1'b0;
               end else if (phase_in == 6'd1) begin
                  scl_in = 1'b1;
               end else if (phase_in == 6'd4) begin
                  sda_in = 1'b1;
               end else if (phase_in >= 6'd5) begin
                  last = 1'b1;
               end
            end
            CMD_WRITE: begin
               if (phase_in < 6'd32) begin
                  if (phase_in[1:0] == 2'd0) begin
                     scl_in = 1'b0;
                  end else if (phase_in[1:0] == 2'd1) begin
                     sda_in       = shift_in[7];
                     shift_in     = {shift_in[6:0], 1'b0};
                     bit_count_in = bit_count_in + 4'd1;
                  end else if (phase_in[1:0] == 2'd2) begin
                     scl_in = 1'b1;
                  end
               end else if (phase_in == 6'd32) begin
                  scl_in = 1'b0;
               end else if (phase_in == 6'd33) begin
                  sda_in = 1'b1;
               end else if (phase_in == 6'd34) begin
                  scl_in = 1'b1;
               end else if (phase_in == 6'd35) begin
                  drive_in = 1'b0;
                  ack_in   = !item.sda_in;
               end else begin
                  scl_in   = 1'b0;
                  drive_in = 1'b1;
                  last     = 1'b1;
               end
            end
            CMD_READ: begin
               if (phase_in < 6'd16) begin
                  if (!phase_in[0]) begin
                     if (phase_in == 6'd0) begin
                        sda_in   = 1'b1;
                        drive_in = 1'b0;
                     end else begin
                        shift_in     = {shift_in[6:0], item.sda_in};
                        bit_count_in = bit_count_in + 4'd1;
                     end
                     scl_in = 1'b0;
                  end else begin
                     scl_in = 1'b1;
                  end
               end else if (phase_in == 6'd16) begin
                  shift_in     = {shift_in[6:0], item.sda_in};
                  bit_count_in = bit_count_in + 4'd1;
                  scl_in       = 1'b0;
                  drive_in     = 1'b1;
               end else if (phase_in == 6'd17) begin
                  sda_in = nack_ff;
               end else if (phase_in == 6'd18) begin
                  scl_in = 1'b1;
               end else if (phase_in == 6'd19) begin
                  scl_in = 1'b0;
               end else begin
                  rx_hold_in = shift_in;
                  last       = 1'b1;
               end
            end
            default: begin
               last = 1'b1;
            end
         endcase
      end

      if (last) begin
         active_in  = CMD_NONE;
         phase_in   = '0;
         divider_in = '0;
      end
   end

   // A read latches its NACK choice on the start tick, before the step that uses it.
   always_comb begin
      rsp_next.scl_level   = scl_in;
      rsp_next.sda_level   = sda_in;
      rsp_next.sda_driving = drive_in;
      rsp_next.busy_res    = (active_in != CMD_NONE);
      rsp_next.done_res    = last;
      rsp_next.rx_byte     = rx_hold_in;
      rsp_next.ack_seen    = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_PER_DELAY_RESET;
      end else if (csr_write_enable) begin
         ticks_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= CMD_NONE;
         phase_ff     <= '0;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         divider_ff   <= '0;
         nack_ff      <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         drive_ff     <= 1'b1;
         ack_ff       <= 1'b0;
         rx_hold_ff   <= '0;
      end else if (step) begin
         active_ff    <= active_in;
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         divider_ff   <= divider_in;
         nack_ff      <= nack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         drive_ff     <= drive_in;
         ack_ff       <= ack_in;
         rx_hold_ff   <= rx_hold_in;
      end
   end

endmodule
